[rtl/dswf_pkg.sv]
// ----------------------------------------------------------------------------
// dswf_pkg: shared types and constants of the deferred state write filter
// Holds the request and result structs, the codes, the states and the default sizes.
// ----------------------------------------------------------------------------
package dswf_pkg;

	localparam int GLOBAL_ENTRIES_D  = 256;
	localparam int SAMPLER_ENTRIES_D = 16;
	localparam int STAGE_ENTRIES_D   = 32;
	localparam int STAGES_D          = 4;
	localparam int DIRTY_DEPTH_D     = 4;

	localparam logic [2:0] ACT_SET     = 3'd0;
	localparam logic [2:0] ACT_GET     = 3'd1;
	localparam logic [2:0] ACT_FLUSH   = 3'd2;
	localparam logic [2:0] ACT_CAPTURE = 3'd3;
	localparam logic [2:0] ACT_RESTORE = 3'd4;
	localparam logic [2:0] ACT_CLEAR   = 3'd5;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_UNAV  = 2'd3;

	localparam logic [1:0] SP_GLOBAL  = 2'd0;
	localparam logic [1:0] SP_SAMPLER = 2'd1;
	localparam logic [1:0] SP_TSTAGE  = 2'd2;

	localparam logic [0:0] REG_ENABLE = 1'd0;
	localparam logic [0:0] REG_UNSET  = 1'd1;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  space;
		logic [1:0]  stage;
		logic [7:0]  index;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  out_space;
		logic [1:0]  out_stage;
		logic [7:0]  out_index;
		logic [31:0] out_value;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_GET, S_FL_PICK, S_FL_RD, S_FL_CMP,
		S_CAP_RD, S_CAP_WR, S_RS_RD, S_RS_CMP, S_DONE
	} state_t;

endpackage

[rtl/deferred_state_write_filter_unit.sv]
// ----------------------------------------------------------------------------
// deferred_state_write_filter_unit: shadow cache for device settings
// Defers sets, filters redundant device writes on flush, snapshots state.
// ----------------------------------------------------------------------------
// The receiver cannot stall: every result is shown for one cycle with
// res_valid and must be taken then. A request is taken when start is high
// and busy is low. Stores (pending, applied, snapshot) sit in synchronous
// memories with registered reads, so every request is worked by a
// sequencer and busy rises for the whole of it. Set and get read the
// entry, then write it back (set) or show it (get); rejected requests just
// show their status. A set while disabled goes straight out as a device
// write. Flush reads and compares each dirty list slot, then clears that
// list; a disabled flush just shows its result. Capture and restore walk
// all entries, reading each and then writing it (restore compares first).
// After reset and after clear all, a clearing pass writes the unset marker
// into every entry, one a cycle (TOTAL entries, 448 at the defaults) while
// busy stays high; the clear all result is shown at the start of it.
module deferred_state_write_filter_unit #(
	parameter int GLOBAL_ENTRIES  = dswf_pkg::GLOBAL_ENTRIES_D,
	parameter int SAMPLER_ENTRIES = dswf_pkg::SAMPLER_ENTRIES_D,
	parameter int STAGE_ENTRIES   = dswf_pkg::STAGE_ENTRIES_D,
	parameter int STAGES          = dswf_pkg::STAGES_D,
	parameter int DIRTY_DEPTH     = dswf_pkg::DIRTY_DEPTH_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dswf_pkg::req_t    req,
	output logic              res_valid,
	output dswf_pkg::res_t    res,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import dswf_pkg::*;

	localparam int SBASE = GLOBAL_ENTRIES;
	localparam int TBASE = GLOBAL_ENTRIES + STAGES * SAMPLER_ENTRIES;
	localparam int TOTAL = TBASE + STAGES * STAGE_ENTRIES;
	localparam int AW    = $clog2(TOTAL);
	localparam int CW    = $clog2(DIRTY_DEPTH + 1);
	localparam int DW    = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
	localparam int NL    = 1 + 2 * STAGES;      // number of dirty lists
	localparam int LW    = $clog2(NL + 1);

	// Configuration registers.
	logic        enable_q;
	logic [31:0] unset_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			unset_q  <= '1;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENABLE) enable_q <= cfg_data[0];
			if (cfg_index == REG_UNSET)  unset_q  <= cfg_data;
		end
	end

	// Stores: pending, applied, snapshot and dirty marks, one address port each.
	logic [31:0] pend_mem [TOTAL];
	logic [31:0] appl_mem [TOTAL];
	logic [31:0] snap_mem [TOTAL];
	logic        dirty_mem [TOTAL];
	logic [AW-1:0] addr;
	logic          pend_we, appl_we, snap_we, dirty_we;
	logic [31:0]   pend_wd, appl_wd, snap_wd;
	logic          dirty_wd;
	logic [31:0]   pend_rd, appl_rd, snap_rd;
	logic          dirty_rd;

	always_ff @(posedge clk) begin
		if (pend_we)  pend_mem[addr]  <= pend_wd;
		if (appl_we)  appl_mem[addr]  <= appl_wd;
		if (snap_we)  snap_mem[addr]  <= snap_wd;
		if (dirty_we) dirty_mem[addr] <= dirty_wd;
		pend_rd  <= pend_mem[addr];
		appl_rd  <= appl_mem[addr];
		snap_rd  <= snap_mem[addr];
		dirty_rd <= dirty_mem[addr];
	end

	// Dirty lists: one global list and one sampler and one texture stage list
	// per stage, each of DIRTY_DEPTH small index slots, with counts. List
	// number 0 is global, 1+2*st sampler and 2+2*st texture stage.
	logic [7:0]    glist_q [DIRTY_DEPTH];
	logic [7:0]    slist_q [STAGES][DIRTY_DEPTH];
	logic [7:0]    tlist_q [STAGES][DIRTY_DEPTH];
	logic [CW-1:0] count_q [NL];

	// Address helpers.
	function automatic logic addr_ok(input logic [1:0] sp, input logic [1:0] st,
		input logic [7:0] ix);
		logic ok;
		ok = 1'b0;
		case (sp)
			SP_GLOBAL:  ok = 32'(ix) < GLOBAL_ENTRIES;
			SP_SAMPLER: ok = (32'(st) < STAGES) && (32'(ix) < SAMPLER_ENTRIES);
			SP_TSTAGE:  ok = (32'(st) < STAGES) && (32'(ix) < STAGE_ENTRIES);
			default:    ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [1:0] sp,
		input logic [1:0] st, input logic [7:0] ix);
		logic [AW+9:0] a;
		if (sp == SP_GLOBAL)
			a = (AW+10)'(ix);
		else if (sp == SP_SAMPLER)
			a = (AW+10)'(SBASE) + (AW+10)'(st) * (AW+10)'(SAMPLER_ENTRIES) + (AW+10)'(ix);
		else
			a = (AW+10)'(TBASE) + (AW+10)'(st) * (AW+10)'(STAGE_ENTRIES) + (AW+10)'(ix);
		return a[AW-1:0];
	endfunction

	// List number: 0 global, 1+2*st sampler, 2+2*st texture stage.
	function automatic logic [LW-1:0] list_of(input logic [1:0] sp, input logic [1:0] st);
		logic [LW+2:0] l;
		if (sp == SP_GLOBAL) l = '0;
		else if (sp == SP_SAMPLER) l = (LW+3)'(1) + ((LW+3)'(st) << 1);
		else l = (LW+3)'(2) + ((LW+3)'(st) << 1);
		return l[LW-1:0];
	endfunction

	state_t state_q, state_d;
	req_t   req_q;
	logic [AW-1:0] ptr_q, ptr_d;             // walk pointer through the stores
	logic [LW-1:0] lst_q, lst_d;             // flush: current list
	logic [CW-1:0] slot_q, slot_d;           // flush: current slot
	logic [1:0]    rsp_q, rsp_d;             // walk: space of ptr
	logic [1:0]    rst_q, rst_d;             // walk: stage of ptr
	logic [7:0]    rix_q, rix_d;             // walk: index of ptr
	logic [1:0]    stat_q, stat_d;
	logic          fail_q, fail_d;
	res_t          res_d;
	logic          res_v_d;

	// List-append request from the sequencer.
	logic          app_go, app_clr;
	logic [LW-1:0] app_l;
	logic [7:0]    app_ix;
	logic          zero_all;
	logic [1:0]    app_st;
	logic [DW-1:0] app_slot;

	assign app_st   = 2'((app_l - LW'(1)) >> 1);
	assign app_slot = count_q[app_l][DW-1:0];

	// Space/stage of a flush list, and the index held in its current slot.
	logic [1:0] fl_sp, fl_st;
	always_comb begin
		if (lst_q == '0) begin
			fl_sp = SP_GLOBAL;
			fl_st = '0;
		end else begin
			fl_sp = lst_q[0] ? SP_SAMPLER : SP_TSTAGE;
			fl_st = 2'((lst_q - LW'(1)) >> 1);
		end
	end

	logic [7:0] fl_ix;
	logic [DW-1:0] slot_i;
	assign slot_i = slot_q[DW-1:0];
	always_comb begin
		if (fl_sp == SP_GLOBAL) fl_ix = glist_q[slot_i];
		else if (fl_sp == SP_SAMPLER) fl_ix = slist_q[fl_st][slot_i];
		else fl_ix = tlist_q[fl_st][slot_i];
	end

	always_comb begin
		logic [AW-1:0] nx;
		state_d  = state_q;
		ptr_d    = ptr_q;
		lst_d    = lst_q;
		slot_d   = slot_q;
		rsp_d    = rsp_q;
		rst_d    = rst_q;
		rix_d    = rix_q;
		stat_d   = stat_q;
		fail_d   = fail_q;
		res_v_d  = 1'b0;
		res_d    = '0;
		res_d.last = 1'b1;
		addr     = ptr_q;
		pend_we  = 1'b0; appl_we = 1'b0; snap_we = 1'b0; dirty_we = 1'b0;
		pend_wd  = req_q.value; appl_wd = pend_rd; snap_wd = pend_rd;
		dirty_wd = 1'b0;
		app_go   = 1'b0; app_clr = 1'b0;
		app_l    = list_of(req_q.space, req_q.stage);
		app_ix   = req_q.index;
		zero_all = 1'b0;
		busy     = (state_q != S_IDLE);
		nx       = ptr_q + AW'(1);

		case (state_q)
			S_CLEAR: begin
				pend_we = 1'b1; appl_we = 1'b1; snap_we = 1'b1; dirty_we = 1'b1;
				pend_wd = unset_q; appl_wd = unset_q; snap_wd = unset_q;
				if (32'(ptr_q) == TOTAL - 1) state_d = S_IDLE;
				ptr_d = nx;
			end
			S_IDLE: begin
				if (start) begin
					addr = addr_of(req.space, req.stage, req.index);
					ptr_d = '0;
					state_d = S_DONE;
					stat_d = ST_OK;
					fail_d = 1'b0;
					case (req.action)
						ACT_SET, ACT_GET: begin
							if (!addr_ok(req.space, req.stage, req.index)) stat_d = ST_RANGE;
							else if (req.action == ACT_GET) begin
								if (enable_q) state_d = S_GET;
								else stat_d = ST_UNAV;
							end else if (enable_q) begin
								// Deferred set: mark and append need the old mark.
								if (32'(count_q[list_of(req.space, req.stage)])
										>= DIRTY_DEPTH)
									stat_d = ST_FULL;
								else
									state_d = S_GET;
							end else begin
								// A set while disabled goes straight to the device.
								state_d = S_GET;
							end
						end
						ACT_FLUSH: begin
							lst_d = '0; slot_d = '0;
							if (enable_q) state_d = S_FL_PICK;
						end
						ACT_CAPTURE: state_d = S_CAP_RD;
						ACT_RESTORE: begin
							rsp_d = SP_GLOBAL; rst_d = '0; rix_d = '0;
							if (enable_q) state_d = S_RS_RD;
							else stat_d = ST_UNAV;
						end
						ACT_CLEAR: begin
							zero_all = 1'b1;
							state_d = S_CLEAR;
							res_v_d = 1'b1;
						end
						default: stat_d = ST_RANGE;
					endcase
				end
			end
			S_GET: begin
				// Read data has arrived for the addressed entry.
				addr = addr_of(req_q.space, req_q.stage, req_q.index);
				if (req_q.action == ACT_GET) begin
					res_v_d = 1'b1;
					res_d.kind = KIND_READ;
					res_d.out_space = req_q.space;
					res_d.out_stage = req_q.stage;
					res_d.out_index = req_q.index;
					res_d.out_value = pend_rd;
				end else if (!enable_q) begin
					res_v_d = 1'b1;
					res_d.kind = KIND_WRITE;
					res_d.out_space = req_q.space;
					res_d.out_stage = req_q.stage;
					res_d.out_index = req_q.index;
					res_d.out_value = req_q.value;
				end else begin
					pend_we = 1'b1;
					dirty_we = 1'b1; dirty_wd = 1'b1;
					app_go = !dirty_rd;
					res_v_d = 1'b1;
				end
				state_d = S_IDLE;
			end
			S_FL_PICK: begin
				if (32'(lst_q) == NL) begin
					state_d = S_DONE;
				end else if (slot_q >= count_q[lst_q]) begin
					app_clr = 1'b1; app_l = lst_q;
					lst_d = lst_q + LW'(1);
					slot_d = '0;
				end else if (!addr_ok(fl_sp, fl_st, fl_ix)) begin
					slot_d = slot_q + CW'(1);
				end else begin
					addr = addr_of(fl_sp, fl_st, fl_ix);
					state_d = S_FL_RD;
				end
			end
			S_FL_RD: begin
				addr = addr_of(fl_sp, fl_st, fl_ix);
				dirty_we = 1'b1; dirty_wd = 1'b0;
				if (pend_rd != appl_rd) begin
					appl_we = 1'b1;
					res_v_d = 1'b1;
					res_d.kind = KIND_WRITE;
					res_d.out_space = fl_sp;
					res_d.out_stage = fl_st;
					res_d.out_index = fl_ix;
					res_d.out_value = pend_rd;
					res_d.last = 1'b0;
				end
				slot_d = slot_q + CW'(1);
				state_d = S_FL_PICK;
			end
			S_CAP_RD: state_d = S_CAP_WR;
			S_CAP_WR: begin
				snap_we = 1'b1;
				ptr_d = nx;
				state_d = (32'(ptr_q) == TOTAL - 1) ? S_DONE : S_CAP_RD;
			end
			S_RS_RD: state_d = S_RS_CMP;
			S_RS_CMP: begin
				// Re-set from the snapshot where it differs from pending.
				if (snap_rd != pend_rd) begin
					app_l = list_of(rsp_q, rst_q);
					app_ix = rix_q;
					if (32'(count_q[app_l]) >= DIRTY_DEPTH) begin
						fail_d = 1'b1;
					end else begin
						pend_we = 1'b1; pend_wd = snap_rd;
						dirty_we = 1'b1; dirty_wd = 1'b1;
						app_go = !dirty_rd;
					end
				end
				// Advance space, stage and index alongside the pointer.
				if (rsp_q == SP_GLOBAL) begin
					if (32'(rix_q) == GLOBAL_ENTRIES - 1) begin
						rsp_d = SP_SAMPLER; rix_d = '0; rst_d = '0;
					end else rix_d = rix_q + 8'd1;
				end else if (rsp_q == SP_SAMPLER) begin
					if (32'(rix_q) == SAMPLER_ENTRIES - 1) begin
						rix_d = '0;
						if (32'(rst_q) == STAGES - 1) begin
							rsp_d = SP_TSTAGE; rst_d = '0;
						end else rst_d = rst_q + 2'd1;
					end else rix_d = rix_q + 8'd1;
				end else begin
					if (32'(rix_q) == STAGE_ENTRIES - 1) begin
						rix_d = '0; rst_d = rst_q + 2'd1;
					end else rix_d = rix_q + 8'd1;
				end
				ptr_d = nx;
				if (32'(ptr_q) == TOTAL - 1) begin
					state_d = S_DONE;
					stat_d = (fail_d) ? ST_FULL : ST_OK;
				end else state_d = S_RS_RD;
			end
			S_DONE: begin
				res_v_d = 1'b1;
				res_d.status = stat_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q <= '0;
			lst_q <= '0; slot_q <= '0;
			rsp_q <= '0; rst_q <= '0; rix_q <= '0;
			stat_q <= '0; fail_q <= 1'b0;
			res_valid <= 1'b0;
			for (int l = 0; l < NL; l++) count_q[l] <= '0;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			lst_q <= lst_d; slot_q <= slot_d;
			rsp_q <= rsp_d; rst_q <= rst_d; rix_q <= rix_d;
			stat_q <= stat_d; fail_q <= fail_d;
			res_valid <= res_v_d;
			if (zero_all) begin
				for (int l = 0; l < NL; l++) count_q[l] <= '0;
			end else if (app_clr) begin
				count_q[app_l] <= '0;
			end else if (app_go) begin
				count_q[app_l] <= count_q[app_l] + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		res <= res_d;
		if (state_q == S_IDLE && start) req_q <= req;
		if (app_go && !app_clr && !zero_all) begin
			if (app_l == '0) glist_q[app_slot] <= app_ix;
			else if (app_l[0]) slist_q[app_st][app_slot] <= app_ix;
			else tlist_q[app_st][app_slot] <= app_ix;
		end
	end

endmodule
